// ----- hw/rtl/mhic_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhic_pkg: shared types and constants for the magnetometer calibration block
// Item layouts, command codes, sequencer states and the divider interface.
// ----------------------------------------------------------------------------
package mhic_pkg;

	localparam int SMP_W  = 16;
	localparam int HR_W   = 15;
	localparam int QUOT_W = 17;
	localparam int OUT_W  = 16;
	localparam int CNT_W  = $clog2(QUOT_W);

	localparam logic signed [SMP_W-1:0] SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};
	localparam logic signed [SMP_W-1:0] SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};
	localparam logic [QUOT_W-1:0] OUT_POS_MAX = QUOT_W'(32767);
	localparam logic [QUOT_W-1:0] OUT_NEG_MAG = QUOT_W'(32768);
	localparam logic [OUT_W-1:0] OUT_POS_SAT = 16'h7fff;
	localparam logic [OUT_W-1:0] OUT_NEG_SAT = 16'h8000;

	typedef enum logic [1:0] {
		CMD_START   = 2'd0,
		CMD_SAMPLE  = 2'd1,
		CMD_FINISH  = 2'd2,
		CMD_MEASURE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BOUNDS,
		ST_PREP,
		ST_CHECK,
		ST_DIV_WAIT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		cmd_t                    cmd;
		logic signed [SMP_W-1:0] sample_x;
		logic signed [SMP_W-1:0] sample_y;
		logic signed [SMP_W-1:0] sample_z;
	} sample_item_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] field_x;
		logic signed [OUT_W-1:0] field_y;
		logic signed [OUT_W-1:0] field_z;
		logic                    is_normalized;
		logic                    clipped;
	} field_item_t;

	typedef struct packed {
		logic              start;
		logic [HR_W-1:0]   rem_init;
		logic [QUOT_W-1:0] num;
		logic [HR_W-1:0]   divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [QUOT_W-1:0] quot;
	} div_rsp_t;

endpackage

// ----- hw/rtl/mhic_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhic_div: serial restoring divider
// One quotient bit per cycle, remainder seeded from the upper dividend bits.
// ----------------------------------------------------------------------------
module mhic_div (
	input  logic              clk,
	input  logic              arst_n,
	input  mhic_pkg::div_req_t req,
	output mhic_pkg::div_rsp_t rsp
);

	logic                          busy_q;
	logic                          done_q;
	logic [mhic_pkg::CNT_W-1:0]    cnt_q;
	logic [mhic_pkg::HR_W-1:0]     rem_q;
	logic [mhic_pkg::QUOT_W-1:0]   num_q;
	logic [mhic_pkg::QUOT_W-1:0]   quot_q;
	logic [mhic_pkg::HR_W-1:0]     div_q;

	logic [mhic_pkg::HR_W:0]       trial;
	logic [mhic_pkg::HR_W:0]       diff;
	logic                          ge;
	logic [mhic_pkg::HR_W-1:0]     rem_d;

	always_comb begin
		trial = {rem_q, num_q[mhic_pkg::QUOT_W-1]};
		ge    = trial >= {1'b0, div_q};
		diff  = trial - {1'b0, div_q};
		rem_d = ge ? diff[mhic_pkg::HR_W-1:0] : trial[mhic_pkg::HR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (req.start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == mhic_pkg::CNT_W'(mhic_pkg::QUOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					done_q <= 1'b0;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem_init;
			num_q <= req.num;
			div_q <= req.divisor;
		end else if (busy_q) begin
			rem_q  <= rem_d;
			num_q  <= {num_q[mhic_pkg::QUOT_W-2:0], 1'b0};
			quot_q <= {quot_q[mhic_pkg::QUOT_W-2:0], ge};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

// ----- hw/rtl/magnetometer_hard_iron_calibration.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetometer_hard_iron_calibration: min/max hard-iron calibration
// Tracks per-axis bounds, derives offset and half-range, and scales
// measurements to fixed point through one shared serial divider.
//
//   channel  signals                                   payload
//   sample   sample_valid, sample_stall, sample_item   command and raw x/y/z
//   field    field_valid, field_stall, field_item      corrected x/y/z, flags
//
// start, sample and finish: accept, then one bounds step per axis
// calibrated measure: accept, then per axis a prep and a check step, the
// serial division and its done step, then the output load; an axis whose
// quotient would overflow the divider's quotient skips the divider
// raw measure: accept, output load; output register holds a result while stalled
// no item is taken until the previous one has left the sequencer
// calibration state resets at once: zero bounds, zero offset, half-range one
// ----------------------------------------------------------------------------
module magnetometer_hard_iron_calibration #(
	parameter int FRAC_BITS = 12
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       sample_valid,
	output logic                       sample_stall,
	input  mhic_pkg::sample_item_t     sample_item,
	output logic                       field_valid,
	input  logic                       field_stall,
	output mhic_pkg::field_item_t      field_item
);

	localparam int SH    = mhic_pkg::QUOT_W - FRAC_BITS;
	localparam int CMP_W = mhic_pkg::HR_W + SH;
	localparam int MSH_W = mhic_pkg::SMP_W + FRAC_BITS;

	mhic_pkg::state_t state_q, state_d;
	logic [1:0]       axis_q;
	logic             last_axis;

	logic signed [mhic_pkg::SMP_W-1:0] min_q [3];
	logic signed [mhic_pkg::SMP_W-1:0] max_q [3];
	logic signed [mhic_pkg::SMP_W-1:0] off_q [3];
	logic [mhic_pkg::HR_W-1:0]         hr_q  [3];
	logic                              seen_q;
	logic                              cal_q;

	mhic_pkg::cmd_t                    cmd_q;
	logic signed [mhic_pkg::SMP_W-1:0] smp_q [3];
	logic [mhic_pkg::SMP_W-1:0]        mag_q;
	logic                              neg_q;
	logic [mhic_pkg::OUT_W-1:0]        res_q [3];
	logic                              clip_q;
	mhic_pkg::field_item_t             out_q;
	logic                              out_valid_q;

	logic take_in;
	logic ld_out;
	logic wr_res;
	logic ovf;

	mhic_pkg::div_req_t div_req;
	mhic_pkg::div_rsp_t div_rsp;

	// datapath for the current axis
	logic signed [mhic_pkg::SMP_W-1:0] s_cur;
	logic signed [mhic_pkg::SMP_W-1:0] mn_cur;
	logic signed [mhic_pkg::SMP_W-1:0] mx_cur;
	logic signed [mhic_pkg::SMP_W:0]   sum;
	logic signed [mhic_pkg::SMP_W:0]   span;
	logic signed [mhic_pkg::SMP_W:0]   d;
	logic signed [mhic_pkg::SMP_W:0]   d_neg;
	logic [CMP_W-1:0]                  hr_lim;
	logic [MSH_W-1:0]                  mag_sh;
	logic [mhic_pkg::QUOT_W-1:0]       q_src;
	logic [mhic_pkg::QUOT_W-1:0]       q_neg;
	logic [mhic_pkg::OUT_W-1:0]        r_val;
	logic                              r_clip;

	always_comb begin
		s_cur  = smp_q[axis_q];
		mn_cur = min_q[axis_q];
		mx_cur = max_q[axis_q];
		sum    = {mx_cur[mhic_pkg::SMP_W-1], mx_cur} + {mn_cur[mhic_pkg::SMP_W-1], mn_cur};
		span   = {mx_cur[mhic_pkg::SMP_W-1], mx_cur} - {mn_cur[mhic_pkg::SMP_W-1], mn_cur};
		d      = {s_cur[mhic_pkg::SMP_W-1], s_cur}
		         - {off_q[axis_q][mhic_pkg::SMP_W-1], off_q[axis_q]};
		d_neg  = -d;
		hr_lim = {hr_q[axis_q], {SH{1'b0}}};
		ovf    = CMP_W'(mag_q) >= hr_lim;
		mag_sh = {mag_q, {FRAC_BITS{1'b0}}};
		q_src  = (state_q == mhic_pkg::ST_CHECK) ? {mhic_pkg::QUOT_W{1'b1}} : div_rsp.quot;
		q_neg  = mhic_pkg::QUOT_W'(0) - q_src;
		if (neg_q) begin
			r_clip = q_src > mhic_pkg::OUT_NEG_MAG;
			r_val  = r_clip ? mhic_pkg::OUT_NEG_SAT : q_neg[mhic_pkg::OUT_W-1:0];
		end else begin
			r_clip = q_src > mhic_pkg::OUT_POS_MAX;
			r_val  = r_clip ? mhic_pkg::OUT_POS_SAT : q_src[mhic_pkg::OUT_W-1:0];
		end
	end

	assign last_axis = axis_q == 2'd2;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mhic_pkg::ST_IDLE: begin
				if (take_in) begin
					if (sample_item.cmd == mhic_pkg::CMD_MEASURE)
						state_d = cal_q ? mhic_pkg::ST_PREP : mhic_pkg::ST_EMIT;
					else
						state_d = mhic_pkg::ST_BOUNDS;
				end
			end
			mhic_pkg::ST_BOUNDS: begin
				if (last_axis)
					state_d = mhic_pkg::ST_IDLE;
			end
			mhic_pkg::ST_PREP: begin
				state_d = mhic_pkg::ST_CHECK;
			end
			mhic_pkg::ST_CHECK: begin
				if (!ovf)
					state_d = mhic_pkg::ST_DIV_WAIT;
				else
					state_d = last_axis ? mhic_pkg::ST_EMIT : mhic_pkg::ST_PREP;
			end
			mhic_pkg::ST_DIV_WAIT: begin
				if (div_rsp.done)
					state_d = last_axis ? mhic_pkg::ST_EMIT : mhic_pkg::ST_PREP;
			end
			mhic_pkg::ST_EMIT: begin
				if (ld_out)
					state_d = mhic_pkg::ST_IDLE;
			end
			default: begin
				state_d = mhic_pkg::ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		sample_stall     = state_q != mhic_pkg::ST_IDLE;
		take_in          = sample_valid && (state_q == mhic_pkg::ST_IDLE);
		ld_out           = (state_q == mhic_pkg::ST_EMIT) && (!out_valid_q || !field_stall);
		wr_res           = ((state_q == mhic_pkg::ST_CHECK) && ovf)
		                   || ((state_q == mhic_pkg::ST_DIV_WAIT) && div_rsp.done);
		div_req.start    = (state_q == mhic_pkg::ST_CHECK) && !ovf;
		div_req.rem_init = mhic_pkg::HR_W'(mag_q >> SH);
		div_req.num      = mag_sh[mhic_pkg::QUOT_W-1:0];
		div_req.divisor  = hr_q[axis_q];
	end

	mhic_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mhic_pkg::ST_IDLE;
			axis_q      <= 2'd0;
			out_valid_q <= 1'b0;
			seen_q      <= 1'b0;
			cal_q       <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				min_q[i] <= '0;
				max_q[i] <= '0;
				off_q[i] <= '0;
				hr_q[i]  <= mhic_pkg::HR_W'(1);
			end
		end else begin
			state_q <= state_d;
			if (take_in)
				axis_q <= 2'd0;
			else if ((state_q == mhic_pkg::ST_BOUNDS) || wr_res)
				axis_q <= last_axis ? 2'd0 : axis_q + 2'd1;
			if (ld_out)
				out_valid_q <= 1'b1;
			else if (!field_stall)
				out_valid_q <= 1'b0;
			if (state_q == mhic_pkg::ST_BOUNDS) begin
				case (cmd_q)
					mhic_pkg::CMD_START: begin
						min_q[axis_q] <= mhic_pkg::SMP_MAX;
						max_q[axis_q] <= mhic_pkg::SMP_MIN;
						if (last_axis)
							seen_q <= 1'b0;
					end
					mhic_pkg::CMD_SAMPLE: begin
						if (s_cur < mn_cur)
							min_q[axis_q] <= s_cur;
						if (s_cur > mx_cur)
							max_q[axis_q] <= s_cur;
						if (last_axis)
							seen_q <= 1'b1;
					end
					mhic_pkg::CMD_FINISH: begin
						if (!seen_q) begin
							off_q[axis_q] <= '0;
							hr_q[axis_q]  <= mhic_pkg::HR_W'(1);
						end else begin
							off_q[axis_q] <= sum[mhic_pkg::SMP_W:1];
							if (span < 2)
								hr_q[axis_q] <= mhic_pkg::HR_W'(1);
							else
								hr_q[axis_q] <= span[mhic_pkg::HR_W:1];
						end
						if (last_axis)
							cal_q <= 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			cmd_q    <= sample_item.cmd;
			smp_q[0] <= sample_item.sample_x;
			smp_q[1] <= sample_item.sample_y;
			smp_q[2] <= sample_item.sample_z;
			res_q[0] <= sample_item.sample_x;
			res_q[1] <= sample_item.sample_y;
			res_q[2] <= sample_item.sample_z;
			clip_q   <= 1'b0;
		end
		if (state_q == mhic_pkg::ST_PREP) begin
			neg_q <= d[mhic_pkg::SMP_W];
			mag_q <= d[mhic_pkg::SMP_W] ? d_neg[mhic_pkg::SMP_W-1:0] : d[mhic_pkg::SMP_W-1:0];
		end
		if (wr_res) begin
			res_q[axis_q] <= r_val;
			if (r_clip)
				clip_q <= 1'b1;
		end
		if (ld_out) begin
			out_q.field_x       <= res_q[0];
			out_q.field_y       <= res_q[1];
			out_q.field_z       <= res_q[2];
			out_q.is_normalized <= cal_q;
			out_q.clipped       <= clip_q;
		end
	end

	assign field_valid = out_valid_q;
	assign field_item  = out_q;

	a_hr_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(hr_q[0] != '0) && (hr_q[1] != '0) && (hr_q[2] != '0))
		else $error("half-range register reached zero");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == mhic_pkg::ST_DIV_WAIT)
		else $error("divider finished outside the wait state");

	a_start_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	a_raw_no_clip: assert property (@(posedge clk) disable iff (!arst_n)
		(field_valid && !field_item.is_normalized) |-> !field_item.clipped)
		else $error("clip flag set on a raw item");

	a_take_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		take_in |=> state_q != mhic_pkg::ST_IDLE)
		else $error("accepted item did not start the sequencer");

endmodule

// ----- tb/magnetometer_hard_iron_calibration_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetometer_hard_iron_calibration_tb: self-checking bench for the block
// Drives command items and predicts each result in the bench itself. It
// tracks the per-axis bounds, the offset, the half-range and the calibrated
// flag, then compares every result field by field. Directed tests cover
// raw pass-through, the calibration corner cases and a long output hold.
// Random calibration runs follow, first with idle bursts on both sides, then without.
// ----------------------------------------------------------------------------
module magnetometer_hard_iron_calibration_tb;

	localparam int FRAC = 12;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 80;

	logic clk;
	logic arst_n;
	logic sample_valid;
	logic sample_stall;
	mhic_pkg::sample_item_t sample_item;
	logic field_valid;
	logic field_stall;
	mhic_pkg::field_item_t field_item;

	// calibration state as the bench sees it
	logic signed [mhic_pkg::SMP_W-1:0] cal_min [3];
	logic signed [mhic_pkg::SMP_W-1:0] cal_max [3];
	logic signed [mhic_pkg::SMP_W-1:0] cal_offset [3];
	logic [mhic_pkg::HR_W-1:0] cal_halfrange [3];
	bit cal_seen;
	bit cal_done;

	mhic_pkg::field_item_t expected_fields [$];
	int error_count = 0;
	int items_sent;
	int cycle_count = 0;
	bit idle_on;
	bit hold_req;
	bit hold_taken;

	magnetometer_hard_iron_calibration #(
		.FRAC_BITS(FRAC)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample_item(sample_item),
		.field_valid(field_valid),
		.field_stall(field_stall),
		.field_item(field_item)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic predict_field(input mhic_pkg::sample_item_t it);
		logic signed [mhic_pkg::SMP_W-1:0] s [3];
		int sum;
		int span;
		longint d;
		longint mag;
		longint q;
		longint r [3];
		bit neg;
		bit clip;
		mhic_pkg::field_item_t res;
		s[0] = it.sample_x;
		s[1] = it.sample_y;
		s[2] = it.sample_z;
		clip = 1'b0;
		case (it.cmd)
			mhic_pkg::CMD_START: begin
				for (int i = 0; i < 3; i++) begin
					cal_min[i] = mhic_pkg::SMP_MAX;
					cal_max[i] = mhic_pkg::SMP_MIN;
				end
				cal_seen = 1'b0;
			end
			mhic_pkg::CMD_SAMPLE: begin
				for (int i = 0; i < 3; i++) begin
					if (s[i] < cal_min[i])
						cal_min[i] = s[i];
					if (s[i] > cal_max[i])
						cal_max[i] = s[i];
				end
				cal_seen = 1'b1;
			end
			mhic_pkg::CMD_FINISH: begin
				for (int i = 0; i < 3; i++) begin
					if (!cal_seen) begin
						cal_offset[i] = '0;
						cal_halfrange[i] = mhic_pkg::HR_W'(1);
					end else begin
						sum = int'(cal_max[i]) + int'(cal_min[i]);
						span = int'(cal_max[i]) - int'(cal_min[i]);
						cal_offset[i] = mhic_pkg::SMP_W'(sum >>> 1);
						cal_halfrange[i] = (span < 2) ? mhic_pkg::HR_W'(1)
							: mhic_pkg::HR_W'(span >>> 1);
					end
				end
				cal_done = 1'b1;
			end
			mhic_pkg::CMD_MEASURE: begin
				if (!cal_done) begin
					res.field_x = s[0];
					res.field_y = s[1];
					res.field_z = s[2];
					res.is_normalized = 1'b0;
					res.clipped = 1'b0;
				end else begin
					for (int i = 0; i < 3; i++) begin
						d = longint'(s[i]) - longint'(cal_offset[i]);
						neg = d < 0;
						mag = neg ? -d : d;
						q = (mag << FRAC) / longint'(cal_halfrange[i]);
						if (neg) begin
							if (q > 32768) begin
								q = 32768;
								clip = 1'b1;
							end
							r[i] = -q;
						end else begin
							if (q > 32767) begin
								q = 32767;
								clip = 1'b1;
							end
							r[i] = q;
						end
					end
					res.field_x = mhic_pkg::OUT_W'(r[0]);
					res.field_y = mhic_pkg::OUT_W'(r[1]);
					res.field_z = mhic_pkg::OUT_W'(r[2]);
					res.is_normalized = 1'b1;
					res.clipped = clip;
				end
				expected_fields.push_back(res);
			end
			default: begin
			end
		endcase
	endtask

	task automatic send_item(input mhic_pkg::cmd_t c, input int x, input int y, input int z);
		mhic_pkg::sample_item_t it;
		it.cmd = c;
		it.sample_x = mhic_pkg::SMP_W'(x);
		it.sample_y = mhic_pkg::SMP_W'(y);
		it.sample_z = mhic_pkg::SMP_W'(z);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_item <= it;
		do @(posedge clk); while (sample_stall);
		predict_field(it);
		items_sent++;
	endtask

	// receiver side: random stall bursts, or one long hold when asked
	initial begin
		field_stall <= 1'b0;
		hold_taken = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				field_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				field_stall <= 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				field_stall <= 1'b1;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				field_stall <= 1'b0;
			end else begin
				field_stall <= 1'b0;
			end
		end
	end

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		mhic_pkg::field_item_t exp_item;
		if (arst_n && field_valid && !field_stall) begin
			if (expected_fields.size() == 0) begin
				$display("%0t: unexpected result item, actual %h", $time, field_item);
				error_count++;
			end else begin
				exp_item = expected_fields.pop_front();
				check_field("field_x", int'(exp_item.field_x), int'(field_item.field_x));
				check_field("field_y", int'(exp_item.field_y), int'(field_item.field_y));
				check_field("field_z", int'(exp_item.field_z), int'(field_item.field_z));
				check_field("is_normalized", int'(exp_item.is_normalized),
					int'(field_item.is_normalized));
				check_field("clipped", int'(exp_item.clipped), int'(field_item.clipped));
			end
		end
	end

	// uncalibrated block passes raw counts through
	task automatic test_raw_passthrough();
		send_item(mhic_pkg::CMD_MEASURE, 0, 0, 0);
		send_item(mhic_pkg::CMD_MEASURE, 32767, -32768, 1);
		send_item(mhic_pkg::CMD_MEASURE, -1, 16'h5555, -21846);
	endtask

	task automatic test_finish_without_samples();
		send_item(mhic_pkg::CMD_FINISH, 0, 0, 0);
		send_item(mhic_pkg::CMD_MEASURE, 1, -1, 0);
		send_item(mhic_pkg::CMD_MEASURE, 8, -8, 7);
		send_item(mhic_pkg::CMD_START, 123, -456, 789);
		send_item(mhic_pkg::CMD_FINISH, 0, 0, 0);
		send_item(mhic_pkg::CMD_MEASURE, -9, 32767, -32768);
	endtask

	task automatic test_sample_without_start();
		send_item(mhic_pkg::CMD_SAMPLE, 100, -200, 7);
		send_item(mhic_pkg::CMD_FINISH, 0, 0, 0);
		send_item(mhic_pkg::CMD_MEASURE, 100, -200, -50);
	endtask

	task automatic test_full_range();
		send_item(mhic_pkg::CMD_START, 0, 0, 0);
		send_item(mhic_pkg::CMD_SAMPLE, 32767, 32767, 32767);
		send_item(mhic_pkg::CMD_SAMPLE, -32768, -32768, -32768);
		send_item(mhic_pkg::CMD_FINISH, 0, 0, 0);
		send_item(mhic_pkg::CMD_MEASURE, 32767, -32768, 0);
	endtask

	task automatic test_narrow_range();
		send_item(mhic_pkg::CMD_START, 0, 0, 0);
		send_item(mhic_pkg::CMD_SAMPLE, 5, 5, -3);
		send_item(mhic_pkg::CMD_SAMPLE, 6, 5, -1);
		send_item(mhic_pkg::CMD_FINISH, 0, 0, 0);
		send_item(mhic_pkg::CMD_MEASURE, 7, 4, -2);
	endtask

	// old offset and half-range stay in force until the next finish
	task automatic test_start_keeps_calibration();
		send_item(mhic_pkg::CMD_START, 0, 0, 0);
		send_item(mhic_pkg::CMD_SAMPLE, 1000, -3000, 20000);
		send_item(mhic_pkg::CMD_MEASURE, 6, 5, -2);
		send_item(mhic_pkg::CMD_FINISH, 0, 0, 0);
		send_item(mhic_pkg::CMD_SAMPLE, -1000, 3000, -20000);
		send_item(mhic_pkg::CMD_FINISH, 0, 0, 0);
		send_item(mhic_pkg::CMD_MEASURE, 500, -500, 12345);
	endtask

	// output held while the block keeps computing, so its input stalls
	task automatic test_output_hold();
		hold_req = 1'b1;
		for (int i = 0; i < 8; i++)
			send_item(mhic_pkg::CMD_MEASURE, $urandom_range(0, 65535) - 32768,
				$urandom_range(0, 4000) - 2000, $urandom_range(0, 40000) - 20000);
	endtask

	function automatic int pick_axis(input int centre, input int spread);
		int v;
		case ($urandom_range(0, 9))
			0: v = int'($urandom_range(0, 65535)) - 32768;
			1: v = $urandom_range(0, 1) ? 32767 : -32768;
			default: v = centre + int'($urandom_range(0, 2 * spread)) - spread;
		endcase
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v;
	endfunction

	function automatic int pick_spread();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 1;
			2: return 3;
			3: return 60;
			4: return 2500;
			default: return 32767;
		endcase
	endfunction

	task automatic test_random_runs(input int count);
		int target;
		int centre [3];
		int spread;
		target = items_sent + count;
		while (items_sent < target) begin
			if ($urandom_range(0, 99) < 80) begin
				spread = pick_spread();
				for (int i = 0; i < 3; i++)
					centre[i] = int'($urandom_range(0, 65535)) - 32768;
				send_item(mhic_pkg::CMD_START, pick_axis(0, 32767), pick_axis(0, 32767),
					pick_axis(0, 32767));
				repeat ($urandom_range(1, 10))
					send_item(mhic_pkg::CMD_SAMPLE, pick_axis(centre[0], spread),
						pick_axis(centre[1], spread), pick_axis(centre[2], spread));
				send_item(mhic_pkg::CMD_FINISH, pick_axis(0, 32767), pick_axis(0, 32767),
					pick_axis(0, 32767));
				repeat ($urandom_range(1, 8))
					send_item(mhic_pkg::CMD_MEASURE, pick_axis(centre[0], 2 * spread + 8),
						pick_axis(centre[1], 2 * spread + 8),
						pick_axis(centre[2], 2 * spread + 8));
			end else begin
				repeat ($urandom_range(1, 4))
					send_item(mhic_pkg::cmd_t'($urandom_range(0, 3)),
						int'($urandom_range(0, 65535)) - 32768,
						int'($urandom_range(0, 65535)) - 32768,
						int'($urandom_range(0, 65535)) - 32768);
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		sample_valid <= 1'b0;
		sample_item <= '0;
		hold_req = 1'b0;
		items_sent = 0;
		idle_on = 1'b1;
		for (int i = 0; i < 3; i++) begin
			cal_min[i] = '0;
			cal_max[i] = '0;
			cal_offset[i] = '0;
			cal_halfrange[i] = mhic_pkg::HR_W'(1);
		end
		cal_seen = 1'b0;
		cal_done = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_raw_passthrough();
		test_finish_without_samples();
		test_sample_without_start();
		test_full_range();
		test_narrow_range();
		test_start_keeps_calibration();
		test_output_hold();
		test_random_runs(1200);
		idle_on = 1'b0;
		test_random_runs(150);

		sample_valid <= 1'b0;
		while (expected_fields.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/mhic_pkg.sv
hw/rtl/mhic_div.sv
hw/rtl/magnetometer_hard_iron_calibration.sv
tb/magnetometer_hard_iron_calibration_tb.sv
